@@ src/vssa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, field layouts, codes and defaults of the voice slot allocator.
package vssa_pkg;

    localparam int NUM_SLOTS_DEF = 32;

    localparam int OP_W       = 3;
    localparam int SLOT_W     = 5;
    localparam int TIME_W     = 32;
    localparam int DIST_W     = 24;
    localparam int REM_W      = 24;
    localparam int SPEED_W    = 16;
    localparam int MARK_W     = 4;
    localparam int TRAVEL_W   = TIME_W + SPEED_W;
    localparam int S_TDATA_W  = 88;
    localparam int M_TDATA_W  = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SPEED_W-1:0] SOUND_SPEED_RST = 16'd343;

    // word index of the register (paddr[2])
    localparam logic REG_SOUND_SPEED = 1'b0;

    localparam logic [OP_W-1:0] OP_LOCAL     = 3'd0;
    localparam logic [OP_W-1:0] OP_WORLD     = 3'd1;
    localparam logic [OP_W-1:0] OP_WORLD_IMP = 3'd2;
    localparam logic [OP_W-1:0] OP_FIXED     = 3'd3;
    localparam logic [OP_W-1:0] OP_UPDATE    = 3'd4;
    localparam logic [OP_W-1:0] OP_RELEASE   = 3'd5;

    localparam int MB_WORLD     = 0;
    localparam int MB_FIXED     = 1;
    localparam int MB_IGNORING  = 2;
    localparam int MB_IMPORTANT = 3;

    localparam logic [MARK_W-1:0] MARKS_LOCAL     = 4'b0000;
    localparam logic [MARK_W-1:0] MARKS_WORLD     = 4'b0101;
    localparam logic [MARK_W-1:0] MARKS_WORLD_IMP = 4'b1101;
    localparam logic [MARK_W-1:0] MARKS_FIXED     = 4'b0011;

    typedef struct packed {
        logic [1:0]        pad;
        logic              ignoring;
        logic [REM_W-1:0]  remaining;
        logic [DIST_W-1:0] distance;
        logic [TIME_W-1:0] now;
        logic [SLOT_W-1:0] slot_index;
    } s_beat_t;

    typedef struct packed {
        logic              stole_playing;
        logic              stole;
        logic [SLOT_W-1:0] granted_slot;
        logic              granted;
    } m_beat_t;

    typedef struct packed {
        logic [MARK_W-1:0] marks;
        logic [TIME_W-1:0] start_time;
        logic [DIST_W-1:0] distance;
        logic [REM_W-1:0]  remaining;
    } entry_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic rd_slot;
        logic rel_slot;
        logic decide;
        logic upd_write;
        logic res_none;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_maint;
        logic is_release;
        logic slot_ok;
        logic scan_last;
        logic pipe_empty;
        logic out_free;
    } sts_t;

endpackage

@@ src/vssa_ctrl.sv @@
`timescale 1ns / 1ps
// Request sequencer of the voice slot allocator.
module vssa_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  vssa_pkg::sts_t  sts,
    output vssa_pkg::cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_DISPATCH = 7'b0000010,
        ST_SCAN     = 7'b0000100,
        ST_DRAIN    = 7'b0001000,
        ST_DECIDE   = 7'b0010000,
        ST_UPDATE   = 7'b0100000,
        ST_RESULT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.is_alloc) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else if (sts.is_maint && sts.slot_ok) begin
                    if (sts.is_release) begin
                        cmd.rel_slot = 1'b1;
                        state_next   = ST_RESULT;
                    end else begin
                        cmd.rd_slot = 1'b1;
                        state_next  = ST_UPDATE;
                    end
                end else begin
                    cmd.res_none = 1'b1;
                    state_next   = ST_RESULT;
                end
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (sts.pipe_empty) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = ST_RESULT;
            end
            ST_UPDATE: begin
                cmd.upd_write = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/vssa_datapath.sv @@
`timescale 1ns / 1ps
// Slot table, victim scan pipeline, result and output registers.
module vssa_datapath #(
    parameter int NUM_SLOTS = vssa_pkg::NUM_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [vssa_pkg::OP_W-1:0]          s_tuser,
    input  logic [vssa_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [vssa_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic [vssa_pkg::SPEED_W-1:0]       sound_speed,
    input  vssa_pkg::cmd_t                     cmd,
    output vssa_pkg::sts_t                     sts
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CHK_W = (IDX_W + 1 > vssa_pkg::SLOT_W) ? IDX_W + 1 : vssa_pkg::SLOT_W;

    vssa_pkg::s_beat_t in_beat;
    assign in_beat = vssa_pkg::s_beat_t'(s_tdata);

    logic [vssa_pkg::OP_W-1:0]   req_op_reg;
    logic [vssa_pkg::SLOT_W-1:0] req_slot_reg;
    logic [vssa_pkg::TIME_W-1:0] req_now_reg;
    logic [vssa_pkg::DIST_W-1:0] req_dist_reg;
    logic [vssa_pkg::REM_W-1:0]  req_rem_reg;
    logic                        req_ign_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_op_reg   <= s_tuser;
            req_slot_reg <= in_beat.slot_index;
            req_now_reg  <= in_beat.now;
            req_dist_reg <= in_beat.distance;
            req_rem_reg  <= in_beat.remaining;
            req_ign_reg  <= in_beat.ignoring;
        end
    end

    logic [CHK_W-1:0] slot_ext;
    logic             slot_in_range;
    logic [IDX_W-1:0] slot_addr;

    assign slot_ext      = CHK_W'(req_slot_reg);
    assign slot_in_range = slot_ext < CHK_W'(NUM_SLOTS);
    assign slot_addr     = IDX_W'(slot_ext);

    logic [NUM_SLOTS-1:0] busy_reg;
    vssa_pkg::entry_t     mem [NUM_SLOTS];

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    vssa_pkg::entry_t wr_entry;

    logic [IDX_W-1:0] cnt_reg;

    vssa_pkg::entry_t rd_entry_reg;
    logic             s1_valid_reg;
    logic             s1_busy_reg;
    logic [IDX_W-1:0] s1_idx_reg;

    assign rd_en   = cmd.scan_step | cmd.rd_slot;
    assign rd_addr = cmd.scan_step ? cnt_reg : slot_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (rd_en) begin
            rd_entry_reg <= mem[rd_addr];
            s1_busy_reg  <= busy_reg[rd_addr];
            s1_idx_reg   <= rd_addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            cnt_reg <= '0;
        end else if (cmd.scan_step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // stage 2: travel of the sound front since its start
    logic [vssa_pkg::TIME_W-1:0]   elapsed;
    logic [vssa_pkg::TRAVEL_W-1:0] travel;

    assign elapsed = req_now_reg - rd_entry_reg.start_time;
    assign travel  = vssa_pkg::TRAVEL_W'(elapsed) * vssa_pkg::TRAVEL_W'(sound_speed);

    logic                          s2_valid_reg;
    logic                          s2_busy_reg;
    logic [IDX_W-1:0]              s2_idx_reg;
    logic [vssa_pkg::MARK_W-1:0]   s2_marks_reg;
    logic [vssa_pkg::DIST_W-1:0]   s2_dist_reg;
    logic [vssa_pkg::REM_W-1:0]    s2_rem_reg;
    logic [vssa_pkg::TRAVEL_W-1:0] s2_travel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.scan_step;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s2_busy_reg   <= s1_busy_reg;
        s2_idx_reg    <= s1_idx_reg;
        s2_marks_reg  <= rd_entry_reg.marks;
        s2_dist_reg   <= rd_entry_reg.distance;
        s2_rem_reg    <= rd_entry_reg.remaining;
        s2_travel_reg <= travel;
    end

    // stage 3: fold the slot into every candidate at once
    logic s2_roam;
    logic s2_ign;
    logic s2_imp;
    logic s2_passed;

    assign s2_roam   = s2_busy_reg & s2_marks_reg[vssa_pkg::MB_WORLD] &
                       ~s2_marks_reg[vssa_pkg::MB_FIXED];
    assign s2_ign    = s2_marks_reg[vssa_pkg::MB_IGNORING];
    assign s2_imp    = s2_marks_reg[vssa_pkg::MB_IMPORTANT];
    assign s2_passed = s2_travel_reg > vssa_pkg::TRAVEL_W'(s2_dist_reg);

    logic                        free_found_reg, pass_found_reg, wn_found_reg, wi_found_reg;
    logic                        far_found_reg, loc_found_reg;
    logic [IDX_W-1:0]            free_idx_reg, pass_idx_reg, wn_idx_reg, wi_idx_reg;
    logic [IDX_W-1:0]            far_idx_reg, loc_idx_reg;
    logic [vssa_pkg::DIST_W-1:0] wn_dist_reg, wi_dist_reg, far_dist_reg;
    logic [vssa_pkg::REM_W-1:0]  loc_rem_reg;
    logic                        far_ign_reg, loc_ign_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.scan_start) begin
            free_found_reg <= 1'b0;
            pass_found_reg <= 1'b0;
            wn_found_reg   <= 1'b0;
            wi_found_reg   <= 1'b0;
            far_found_reg  <= 1'b0;
            loc_found_reg  <= 1'b0;
            wn_dist_reg    <= '0;
            wi_dist_reg    <= '0;
        end else if (s2_valid_reg) begin
            if (!s2_busy_reg && !free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= s2_idx_reg;
            end
            if (s2_roam && s2_ign && s2_passed && !pass_found_reg) begin
                pass_found_reg <= 1'b1;
                pass_idx_reg   <= s2_idx_reg;
            end
            if (s2_roam && s2_ign && !s2_imp && (s2_dist_reg > wn_dist_reg)) begin
                wn_found_reg <= 1'b1;
                wn_idx_reg   <= s2_idx_reg;
                wn_dist_reg  <= s2_dist_reg;
            end
            if (s2_roam && s2_ign && s2_imp && (s2_dist_reg > wi_dist_reg)) begin
                wi_found_reg <= 1'b1;
                wi_idx_reg   <= s2_idx_reg;
                wi_dist_reg  <= s2_dist_reg;
            end
            if (s2_roam && (!far_found_reg || (s2_dist_reg > far_dist_reg))) begin
                far_found_reg <= 1'b1;
                far_idx_reg   <= s2_idx_reg;
                far_dist_reg  <= s2_dist_reg;
                far_ign_reg   <= s2_ign;
            end
            if (s2_busy_reg && !s2_marks_reg[vssa_pkg::MB_FIXED] &&
                (!loc_found_reg || (s2_rem_reg < loc_rem_reg))) begin
                loc_found_reg <= 1'b1;
                loc_idx_reg   <= s2_idx_reg;
                loc_rem_reg   <= s2_rem_reg;
                loc_ign_reg   <= s2_ign;
            end
        end
    end

    // victim choice
    logic                        wv_found, wv_stole, wv_play;
    logic [IDX_W-1:0]            wv_idx;
    logic                        dec_found, dec_stole, dec_play;
    logic [IDX_W-1:0]            dec_idx;
    logic [vssa_pkg::MARK_W-1:0] dec_marks;

    always_comb begin
        wv_found = 1'b0;
        wv_stole = 1'b0;
        wv_play  = 1'b0;
        wv_idx   = free_idx_reg;
        if (free_found_reg) begin
            wv_found = 1'b1;
        end else if (far_found_reg) begin
            wv_found = 1'b1;
            wv_stole = 1'b1;
            if (pass_found_reg) begin
                wv_idx = pass_idx_reg;
            end else if (wn_found_reg) begin
                wv_idx = wn_idx_reg;
            end else if (wi_found_reg) begin
                wv_idx = wi_idx_reg;
            end else begin
                wv_idx  = far_idx_reg;
                wv_play = ~far_ign_reg;
            end
        end
    end

    always_comb begin
        dec_found = 1'b0;
        dec_stole = 1'b0;
        dec_play  = 1'b0;
        dec_idx   = free_idx_reg;
        dec_marks = vssa_pkg::MARKS_LOCAL;
        case (req_op_reg)
            vssa_pkg::OP_LOCAL: begin
                if (wv_found) begin
                    dec_found = 1'b1;
                    dec_stole = wv_stole;
                    dec_play  = wv_play;
                    dec_idx   = wv_idx;
                end else if (loc_found_reg) begin
                    dec_found = 1'b1;
                    dec_stole = 1'b1;
                    dec_play  = ~loc_ign_reg;
                    dec_idx   = loc_idx_reg;
                end
            end
            vssa_pkg::OP_WORLD: begin
                dec_found = free_found_reg;
                dec_marks = vssa_pkg::MARKS_WORLD;
            end
            vssa_pkg::OP_WORLD_IMP: begin
                dec_found = wv_found;
                dec_stole = wv_stole;
                dec_play  = wv_play;
                dec_idx   = wv_idx;
                dec_marks = vssa_pkg::MARKS_WORLD_IMP;
            end
            vssa_pkg::OP_FIXED: begin
                dec_found = free_found_reg;
                dec_marks = vssa_pkg::MARKS_FIXED;
            end
            default: begin
                dec_found = 1'b0;
            end
        endcase
    end

    // update keeps the start time; the ignoring mark only moves on roaming voices
    logic                        rd_roam;
    logic [vssa_pkg::MARK_W-1:0] upd_marks;

    assign rd_roam = rd_entry_reg.marks[vssa_pkg::MB_WORLD] &
                     ~rd_entry_reg.marks[vssa_pkg::MB_FIXED];

    always_comb begin
        upd_marks = rd_entry_reg.marks;
        if (rd_roam) begin
            upd_marks[vssa_pkg::MB_IGNORING] = req_ign_reg;
        end
    end

    assign wr_en   = (cmd.decide & dec_found) | cmd.upd_write;
    assign wr_addr = cmd.upd_write ? slot_addr : dec_idx;

    always_comb begin
        wr_entry.distance  = req_dist_reg;
        wr_entry.remaining = req_rem_reg;
        if (cmd.upd_write) begin
            wr_entry.marks      = upd_marks;
            wr_entry.start_time = rd_entry_reg.start_time;
        end else begin
            wr_entry.marks      = dec_marks;
            wr_entry.start_time = req_now_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else begin
            if (cmd.rel_slot) begin
                busy_reg[slot_addr] <= 1'b0;
            end
            if (cmd.decide && dec_found) begin
                busy_reg[dec_idx] <= 1'b1;
            end
        end
    end

    vssa_pkg::m_beat_t res_reg;

    always_ff @(posedge aclk) begin
        if (cmd.res_none) begin
            res_reg <= '0;
        end else if (cmd.rel_slot || cmd.upd_write) begin
            res_reg.granted       <= 1'b1;
            res_reg.granted_slot  <= req_slot_reg;
            res_reg.stole         <= 1'b0;
            res_reg.stole_playing <= 1'b0;
        end else if (cmd.decide) begin
            res_reg.granted       <= dec_found;
            res_reg.granted_slot  <= dec_found ? vssa_pkg::SLOT_W'(dec_idx) : '0;
            res_reg.stole         <= dec_found & dec_stole;
            res_reg.stole_playing <= dec_found & dec_play;
        end
    end

    logic                       out_valid_reg;
    logic [vssa_pkg::M_TDATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        sts.is_alloc   = (req_op_reg == vssa_pkg::OP_LOCAL) ||
                         (req_op_reg == vssa_pkg::OP_WORLD) ||
                         (req_op_reg == vssa_pkg::OP_WORLD_IMP) ||
                         (req_op_reg == vssa_pkg::OP_FIXED);
        sts.is_maint   = (req_op_reg == vssa_pkg::OP_UPDATE) ||
                         (req_op_reg == vssa_pkg::OP_RELEASE);
        sts.is_release = (req_op_reg == vssa_pkg::OP_RELEASE);
        sts.slot_ok    = slot_in_range && busy_reg[slot_addr];
        sts.scan_last  = (cnt_reg == IDX_W'(NUM_SLOTS - 1));
        sts.pipe_empty = ~s1_valid_reg & ~s2_valid_reg;
        sts.out_free   = ~out_valid_reg | m_tready;
    end

endmodule

@@ src/voice_slot_stealing_allocator_core.sv @@
`timescale 1ns / 1ps
// Top level of the voice slot allocator: register port, sequencer and datapath.
//
// Requests enter as beats on the s_ stream: s_tuser carries the request kind
// (local, world, important world, fixed, update slot, release slot), s_tdata
// the slot index, current tick, distance, remaining samples and ignoring flag.
// One result beat per request leaves on the m_ stream.
// Allocation requests walk the whole slot table once through a three-stage
// read, multiply and compare pipeline; once it drains, any victim found is
// written to the table and the choice is registered as the result. Updates
// read the slot, then rewrite it; release and unknown requests go to the result.
// One request is in work at a time; the next is taken once the result sits
// in the output register, even if the receiver has not taken it yet.
// While m_tready is low the result beat holds and no further request is
// taken once a second result is ready.
// Reset frees every slot at once and loads sound_speed with 343; the slot
// contents need no clearing pass. sound_speed sits at APB address 0.
module voice_slot_stealing_allocator_core #(
    parameter int NUM_SLOTS = vssa_pkg::NUM_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // slot_index[4:0], now[36:5], distance[60:37], remaining[84:61], ignoring[85]
    input  logic [vssa_pkg::S_TDATA_W-1:0]      s_tdata,
    // op[2:0]
    input  logic [vssa_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // granted[0], granted_slot[5:1], stole[6], stole_playing[7]
    output logic [vssa_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [vssa_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [vssa_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [vssa_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic [vssa_pkg::SPEED_W-1:0] speed_reg;
    logic                         reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == vssa_pkg::REG_SOUND_SPEED);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= vssa_pkg::SOUND_SPEED_RST;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            speed_reg <= pwdata[vssa_pkg::SPEED_W-1:0];
        end
    end

    assign prdata = reg_hit ? vssa_pkg::APB_DATA_W'(speed_reg) : '0;

    vssa_pkg::cmd_t cmd;
    vssa_pkg::sts_t sts;

    vssa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vssa_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .sound_speed (speed_reg),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

@@ src/vssa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks of the voice slot allocator, bound to the top level.
module vssa_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [vssa_pkg::M_TDATA_W-1:0]      m_tdata,
    input logic [vssa_pkg::APB_ADDR_W-1:0]     paddr,
    input logic [vssa_pkg::APB_DATA_W-1:0]     prdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
        else $error("refused request carries non-zero fields");

    a_play_implies_steal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7] |-> m_tdata[6] && m_tdata[0])
        else $error("stole_playing without a granted steal");

    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in work");

    a_speed_reset: assert property (@(posedge aclk)
        !aresetn ##1 (paddr[2] == vssa_pkg::REG_SOUND_SPEED) |-> prdata == 32'd343)
        else $error("sound_speed not at its reset value");

endmodule

bind voice_slot_stealing_allocator_core vssa_checker u_vssa_checker (.*);

@@ sim/vssa_checker.sv @@
`timescale 1ns / 1ps
// Stream and register monitor for the voice slot allocator: predicts and compares result beats.
module vssa_scoreboard
    import vssa_pkg::*;
#(
    parameter int SLOTS = NUM_SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // slot_index, now, distance, remaining, ignoring, pad
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // op
    input  logic [OP_W-1:0]       s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // granted, granted_slot, stole, stole_playing
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending,
    output int                    results_seen,
    output int                    steals_seen
);

    logic               busy_mirror  [SLOTS];
    logic [MARK_W-1:0]  marks_mirror [SLOTS];
    logic [TIME_W-1:0]  start_mirror [SLOTS];
    logic [DIST_W-1:0]  dist_mirror  [SLOTS];
    logic [REM_W-1:0]   rem_mirror   [SLOTS];
    logic [SPEED_W-1:0] speed_mirror;

    m_beat_t grant_q [$];
    int      mismatches;
    int      result_total;
    int      steal_total;

    initial begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        steals_seen  = 0;
        mismatches   = 0;
        result_total = 0;
        steal_total  = 0;
        speed_mirror = SOUND_SPEED_RST;
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic logic roams(int i);
        return marks_mirror[i][MB_WORLD] && !marks_mirror[i][MB_FIXED];
    endfunction

    function automatic int lowest_free();
        for (int i = 0; i < SLOTS; i++) begin
            if (!busy_mirror[i]) return i;
        end
        return SLOTS;
    endfunction

    function automatic int farthest_ignoring(int first, logic imp);
        int                best;
        logic [DIST_W-1:0] far;
        best = SLOTS;
        far  = '0;
        for (int i = first; i < SLOTS; i++) begin
            if (marks_mirror[i][MB_IMPORTANT] == imp && roams(i) &&
                marks_mirror[i][MB_IGNORING] && dist_mirror[i] > far) begin
                best = i;
                far  = dist_mirror[i];
            end
        end
        return best;
    endfunction

    function automatic int pick_world_slot(logic [TIME_W-1:0] now_v);
        int                  first;
        int                  pick;
        logic [DIST_W-1:0]   far;
        logic [TIME_W-1:0]   elapsed;
        logic [TRAVEL_W-1:0] travel;
        pick = lowest_free();
        if (pick < SLOTS) return pick;
        first = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (roams(i)) first = i;
        end
        if (first >= SLOTS) return SLOTS;
        // a waiting voice whose front has already passed the listener
        for (int i = first; i < SLOTS; i++) begin
            if (roams(i) && marks_mirror[i][MB_IGNORING]) begin
                elapsed = now_v - start_mirror[i];
                travel  = TRAVEL_W'(elapsed) * TRAVEL_W'(speed_mirror);
                if (travel > TRAVEL_W'(dist_mirror[i])) return i;
            end
        end
        pick = farthest_ignoring(first, 1'b0);
        if (pick < SLOTS) return pick;
        pick = farthest_ignoring(first, 1'b1);
        if (pick < SLOTS) return pick;
        pick = first;
        far  = dist_mirror[first];
        for (int i = first + 1; i < SLOTS; i++) begin
            if (roams(i) && dist_mirror[i] > far) begin
                pick = i;
                far  = dist_mirror[i];
            end
        end
        return pick;
    endfunction

    function automatic int pick_local_slot(logic [TIME_W-1:0] now_v);
        int               pick;
        logic [REM_W-1:0] least;
        pick = pick_world_slot(now_v);
        if (pick < SLOTS) return pick;
        pick  = SLOTS;
        least = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!marks_mirror[i][MB_FIXED] && (pick == SLOTS || rem_mirror[i] < least)) begin
                pick  = i;
                least = rem_mirror[i];
            end
        end
        return pick;
    endfunction

    function automatic m_beat_t serve_request(logic [OP_W-1:0] op, s_beat_t b);
        m_beat_t           res;
        int                pick;
        logic [MARK_W-1:0] new_marks;
        res       = '0;
        pick      = SLOTS;
        new_marks = MARKS_LOCAL;
        if (op == OP_UPDATE || op == OP_RELEASE) begin
            if (int'(b.slot_index) >= SLOTS || !busy_mirror[b.slot_index]) return res;
            if (op == OP_RELEASE) begin
                busy_mirror[b.slot_index] = 1'b0;
            end else begin
                dist_mirror[b.slot_index] = b.distance;
                rem_mirror[b.slot_index]  = b.remaining;
                if (roams(b.slot_index)) marks_mirror[b.slot_index][MB_IGNORING] = b.ignoring;
            end
            res.granted      = 1'b1;
            res.granted_slot = b.slot_index;
            return res;
        end
        case (op)
            OP_LOCAL: begin
                pick      = pick_local_slot(b.now);
                new_marks = MARKS_LOCAL;
            end
            OP_WORLD: begin
                pick      = lowest_free();
                new_marks = MARKS_WORLD;
            end
            OP_WORLD_IMP: begin
                pick      = pick_world_slot(b.now);
                new_marks = MARKS_WORLD_IMP;
            end
            OP_FIXED: begin
                pick      = lowest_free();
                new_marks = MARKS_FIXED;
            end
            default: return res;
        endcase
        if (pick >= SLOTS) return res;
        res.granted      = 1'b1;
        res.granted_slot = SLOT_W'(pick);
        if (busy_mirror[pick]) begin
            res.stole         = 1'b1;
            res.stole_playing = !marks_mirror[pick][MB_IGNORING];
        end
        busy_mirror[pick]  = 1'b1;
        marks_mirror[pick] = new_marks;
        start_mirror[pick] = b.now;
        dist_mirror[pick]  = b.distance;
        rem_mirror[pick]   = b.remaining;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        m_beat_t got;
        m_beat_t want;
        m_beat_t pred;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                busy_mirror[i]  = 1'b0;
                marks_mirror[i] = '0;
                start_mirror[i] = '0;
                dist_mirror[i]  = '0;
                rem_mirror[i]   = '0;
            end
            speed_mirror = SOUND_SPEED_RST;
            grant_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_beat_t'(m_tdata);
                result_total++;
                if (got.stole) steal_total++;
                if (grant_q.size() == 0) begin
                    report_mismatch($sformatf("result beat 0x%02h with no request outstanding",
                                              m_tdata));
                end else begin
                    want = grant_q.pop_front();
                    if (got.granted !== want.granted)
                        report_mismatch($sformatf("granted %b, want %b",
                                                  got.granted, want.granted));
                    if (got.granted_slot !== want.granted_slot)
                        report_mismatch($sformatf("granted_slot %0d, want %0d",
                                                  got.granted_slot, want.granted_slot));
                    if (got.stole !== want.stole)
                        report_mismatch($sformatf("stole %b, want %b", got.stole, want.stole));
                    if (got.stole_playing !== want.stole_playing)
                        report_mismatch($sformatf("stole_playing %b, want %b",
                                                  got.stole_playing, want.stole_playing));
                end
            end
            if (s_tvalid && s_tready) begin
                pred    = serve_request(s_tuser, s_beat_t'(s_tdata));
                grant_q = {grant_q, pred};
            end
            if (psel && penable && pready && paddr[2] == REG_SOUND_SPEED) begin
                if (pwrite) begin
                    speed_mirror = pwdata[SPEED_W-1:0];
                end else if (prdata !== APB_DATA_W'(speed_mirror)) begin
                    report_mismatch($sformatf("sound_speed read 0x%08h, want 0x%08h",
                                              prdata, APB_DATA_W'(speed_mirror)));
                end
            end
        end
        fail_count   <= mismatches;
        pending      <= grant_q.size();
        results_seen <= result_total;
        steals_seen  <= steal_total;
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the voice slot allocator: clock, reset, request and register stimulus, verdict.
module tb_top;
    import vssa_pkg::*;

    localparam int SLOTS = NUM_SLOTS_DEF;
    localparam int LIMIT = 1_000_000;
    localparam logic [APB_ADDR_W-1:0] SPEED_ADDR = {REG_SOUND_SPEED, 2'b00};
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // slot_index[4:0], now[36:5], distance[60:37], remaining[84:61], ignoring[85]
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    // op[2:0]
    logic [OP_W-1:0]       s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // granted[0], granted_slot[5:1], stole[6], stole_playing[7]
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                fail_count;
    int                pending;
    int                results_seen;
    int                steals_seen;
    int                cycle_count    = 0;
    int                sent_count     = 0;
    int                settings_count = 0;
    logic              steady         = 1'b0;
    logic [TIME_W-1:0] tick_now       = '0;

    voice_slot_stealing_allocator_core #(.NUM_SLOTS(SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    vssa_scoreboard #(.SLOTS(SLOTS)) u_scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .pending     (pending),
        .results_seen(results_seen),
        .steals_seen (steals_seen)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        m_tready    <= steady || ($urandom_range(0, 99) >= 13);
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("voice_slot_stealing_allocator_core verification failed");
        $finish;
    end

    task automatic request(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] idx,
                           input logic [TIME_W-1:0] now_v, input logic [DIST_W-1:0] dist_v,
                           input logic [REM_W-1:0] rem_v, input logic ign);
        s_beat_t b;
        b            = '0;
        b.slot_index = idx;
        b.now        = now_v;
        b.distance   = dist_v;
        b.remaining  = rem_v;
        b.ignoring   = ign;
        while (!steady && $urandom_range(0, 99) < 13) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // write sound_speed, then read it back
    task automatic set_sound_speed(input logic [SPEED_W-1:0] speed);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SPEED_ADDR;
        pwdata  <= {16'($urandom), speed};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        settings_count++;
    endtask

    task automatic random_requests(input int n);
        logic [OP_W-1:0]   op;
        logic [TIME_W-1:0] t;
        logic [DIST_W-1:0] d;
        logic [REM_W-1:0]  rm;
        int                r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 14)      op = OP_LOCAL;
            else if (r < 30) op = OP_WORLD;
            else if (r < 54) op = OP_WORLD_IMP;
            else if (r < 62) op = OP_FIXED;
            else if (r < 82) op = OP_UPDATE;
            else if (r < 96) op = OP_RELEASE;
            else             op = $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
            if ($urandom_range(0, 39) == 0) tick_now = $urandom();
            else                            tick_now = tick_now + $urandom_range(0, 60);
            t = ($urandom_range(0, 19) == 0) ? $urandom() : tick_now;
            r = $urandom_range(0, 9);
            if (r == 0)      d = '0;
            else if (r == 1) d = '1;
            else if (r == 2) d = DIST_W'($urandom());
            else             d = DIST_W'($urandom_range(0, 40000));
            r = $urandom_range(0, 9);
            if (r == 0)      rm = '0;
            else if (r == 1) rm = '1;
            else if (r == 2) rm = REM_W'($urandom_range(0, 3));
            else if (r < 6)  rm = REM_W'($urandom_range(0, 2000));
            else             rm = REM_W'($urandom());
            request(op, SLOT_W'($urandom_range(0, SLOTS - 1)), t, d, rm,
                    $urandom_range(0, 9) < 6);
            if ($urandom_range(0, 199) == 0) wait_drained();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty table, reset sound speed
        request(OP_RELEASE,   5'd5,  32'd0,        24'd0,       24'd0,       1'b0);
        request(OP_UPDATE,    5'd31, 32'd0,        24'hFFFFFF,  24'hFFFFFF,  1'b1);
        request(OP_SPARE_6,   5'd0,  32'hFFFFFFFF, 24'hFFFFFF,  24'hFFFFFF,  1'b1);
        request(OP_SPARE_7,   5'd31, 32'd0,        24'd0,       24'd0,       1'b0);
        request(OP_LOCAL,     5'd0,  32'd0,        24'd0,       24'hFFFFFF,  1'b0);
        request(OP_WORLD,     5'd0,  32'hFFFFFFFF, 24'hFFFFFF,  24'd0,       1'b1);
        request(OP_WORLD_IMP, 5'd31, 32'hFFFFFFFF, 24'hFFFFFF,  24'hFFFFFF,  1'b1);
        request(OP_FIXED,     5'd0,  32'd100,      24'd1000,    24'd1,       1'b0);
        request(OP_UPDATE,    5'd1,  32'd0,        24'd100,     24'd5,       1'b1);
        request(OP_UPDATE,    5'd1,  32'd0,        24'd200,     24'd6,       1'b0);
        request(OP_UPDATE,    5'd3,  32'd0,        24'hFFFFFF,  24'd0,       1'b1);
        request(OP_UPDATE,    5'd0,  32'd0,        24'd7,       24'd8,       1'b1);
        request(OP_RELEASE,   5'd2,  32'd0,        24'd0,       24'd0,       1'b0);
        request(OP_RELEASE,   5'd2,  32'd0,        24'd0,       24'd0,       1'b0);
        request(OP_WORLD_IMP, 5'd0,  32'h80000000, 24'd0,       24'd0,       1'b0);
        request(OP_LOCAL,     5'd0,  32'hFFFFFFFF, 24'hFFFFFF,  24'hFFFFFF,  1'b1);
        wait_drained();

        set_sound_speed(16'hFFFF);
        random_requests(480);
        wait_drained();

        set_sound_speed(16'd1);
        random_requests(380);
        wait_drained();

        // zero speed: free the table, fill it with fixed voices, then nothing can be stolen
        set_sound_speed(16'd0);
        for (int i = 0; i < SLOTS; i++) request(OP_RELEASE, SLOT_W'(i), tick_now, '0, '0, 1'b0);
        for (int i = 0; i < SLOTS; i++) begin
            request(OP_FIXED, SLOT_W'($urandom()), tick_now + i, DIST_W'($urandom()),
                    REM_W'($urandom()), 1'b1);
        end
        request(OP_LOCAL,     5'd0, tick_now, 24'd10, 24'd10, 1'b0);
        request(OP_WORLD,     5'd0, tick_now, 24'd10, 24'd10, 1'b1);
        request(OP_WORLD_IMP, 5'd0, tick_now, 24'd10, 24'd10, 1'b1);
        request(OP_UPDATE,    5'd4, tick_now, 24'd99, 24'd99, 1'b1);
        request(OP_WORLD_IMP, 5'd9, 32'hFFFFFFFF, '1, '1, 1'b0);
        request(OP_LOCAL,     5'd9, 32'hFFFFFFFF, '1, '1, 1'b1);
        for (int i = 0; i < SLOTS; i += 2) request(OP_RELEASE, SLOT_W'(i), tick_now, '0, '0, 1'b0);
        random_requests(280);
        wait_drained();

        set_sound_speed(16'($urandom_range(1, 65535)));
        steady = 1'b1;
        random_requests(380);
        wait_drained();
        steady = 1'b0;

        set_sound_speed(SOUND_SPEED_RST);
        random_requests(130);
        wait_drained();

        repeat (SLOTS + 10) @(posedge aclk);

        $display("Sent %0d requests across %0d sound speed settings, zero and both ends included.",
                 sent_count, settings_count);
        $display("Checked %0d result beats, %0d of them steals; %0d mismatches.",
                 results_seen, steals_seen, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("voice_slot_stealing_allocator_core verification clean");
        end else begin
            $display("voice_slot_stealing_allocator_core verification failed");
        end
        $finish;
    end

endmodule

@@ voice_slot_stealing_allocator_core.f @@
src/vssa_pkg.sv
src/vssa_ctrl.sv
src/vssa_datapath.sv
src/voice_slot_stealing_allocator_core.sv
src/vssa_checker.sv
sim/vssa_checker.sv
sim/tb_top.sv
